FILE: design/bbe_pkg.sv
// Shared types, constants and the reciprocal table of the 3x3 box blur.
// No dependencies; every other design file imports this package.
package bbe_pkg;

  localparam int CH_W  = 8;
  localparam int NCH   = 3;
  localparam int PIX_W = NCH * CH_W;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;
  localparam int WIDTH_RESET  = 640;
  localparam int HEIGHT_RESET = 480;

  // Item kinds on tuser
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Divide datapath: x = 2*sum + n, q = (x * recip(n)) >> REC_SHIFT
  localparam int SUM_W     = 12;
  localparam int X_W       = 13;
  localparam int CNT_W     = 4;
  localparam int REC_W     = 18;
  localparam int REC_SHIFT = 18;

  localparam int Q_DEPTH = 4;

  // channel 2 = red, 1 = green, 0 = blue
  typedef logic [NCH-1:0][CH_W-1:0] rgb_t;

  // mask bit 0 = top row / left column, bit 2 = bottom row / right column
  typedef struct packed {
    logic       emit;
    logic       last;
    logic [2:0] row_mask;
    logic [2:0] col_mask;
  } bbe_ctrl_t;

  typedef struct packed {
    rgb_t      above2;
    rgb_t      above1;
    rgb_t      cur;
    bbe_ctrl_t ctrl;
  } bbe_entry_t;

  // ceil(2^18 / (2n)); exact for x < 4600
  function automatic logic [REC_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [REC_W-1:0] m;
    case (n)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

FILE: design/bbe_front.sv
// Front end: config registers, frame position, item classification and line store.
// Depends on bbe_pkg.
module bbe_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_valid_i,
  output logic                           s_ready_o,
  input  logic                           cmd_i,
  input  bbe_pkg::rgb_t                  pix_i,
  input  logic                           cfg_valid_i,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbe_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                           push_valid_o,
  output bbe_pkg::bbe_entry_t            push_entry_o,
  input  logic                           push_ready_i
);
  import bbe_pkg::*;

  localparam int XW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int WCW = (CFG_W > WW) ? CFG_W : WW;
  localparam int HCW = (CFG_W > HW) ? CFG_W : HW;
  localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
  localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

  logic [WW-1:0] w_q;
  logic [HW-1:0] h_q;
  logic [XW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic [WCW-1:0] cfg_w_ext;
  logic [HCW-1:0] cfg_h_ext;
  logic [WW-1:0]  w_new;
  logic [HW-1:0]  h_new;
  logic           cfg_wr;

  logic [RW-1:0] h_r, h_p1;
  logic [XW:0]   col_inc;
  logic          drain, ignore, accept, load, leave, bypass;
  logic          case_a, case_b;
  bbe_ctrl_t     ctrl;

  logic                 s1_valid_q;
  logic [XW-1:0]        s1_col_q;
  rgb_t                 s1_pix_q;
  bbe_ctrl_t            s1_ctrl_q;
  logic [2*PIX_W-1:0]   rd_q;
  logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];

  // config: clamp to 1..MAX
  assign cfg_wr    = cfg_valid_i;
  assign cfg_w_ext = WCW'(cfg_data_i);
  assign cfg_h_ext = HCW'(cfg_data_i);
  assign w_new = (cfg_data_i == '0) ? WW'(1) :
                 (cfg_w_ext > WCW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w_ext);
  assign h_new = (cfg_data_i == '0) ? HW'(1) :
                 (cfg_h_ext > HCW'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_h_ext);

  // classification
  assign h_r    = RW'(h_q);
  assign h_p1   = h_r + RW'(1);
  assign drain  = row_q >= h_r;
  assign ignore = !drain && (cmd_i == CMD_FLUSH);
  assign leave  = s1_valid_q && push_ready_i;
  assign s_ready_o = !s1_valid_q || push_ready_i;
  assign accept = s_valid_i && s_ready_o;
  assign load   = accept && !ignore;
  assign bypass = leave && (s1_col_q == col_q);

  // row start emits last pixel of row-2; otherwise pixel (row-1, col-1)
  assign case_a = (col_q == '0) && (row_q >= RW'(2)) && (row_q <= h_p1);
  assign case_b = (col_q != '0) && (row_q >= RW'(1)) && (row_q <= h_r);
  assign col_inc = {1'b0, col_q} + (XW+1)'(1);

  always_comb begin
    ctrl.emit = case_a || case_b;
    ctrl.last = case_a && (row_q == h_p1);
    if (case_a) begin
      ctrl.row_mask = {row_q <= h_r, 1'b1, row_q >= RW'(3)};
      ctrl.col_mask = {1'b0, 1'b1, w_q >= WW'(2)};
    end else begin
      ctrl.row_mask = {row_q < h_r, 1'b1, row_q >= RW'(2)};
      ctrl.col_mask = {1'b1, 1'b1, col_inc > (XW+1)'(2)};
    end
    if (ctrl.last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_inc >= (XW+1)'(w_q)) begin
      col_d = '0;
      row_d = row_q + RW'(1);
    end else begin
      col_d = col_inc[XW-1:0];
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q        <= WW'(W_RST);
      h_q        <= HW'(H_RST);
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (cfg_index_i == REG_WIDTH) begin
          w_q <= w_new;
        end else begin
          h_q <= h_new;
        end
        col_q <= '0;
        row_q <= '0;
      end else if (load) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      s1_valid_q <= load || (s1_valid_q && !leave);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_col_q  <= col_q;
      s1_pix_q  <= drain ? '0 : pix_i;
      s1_ctrl_q <= ctrl;
    end
  end

  // line store word = {row-2, row-1}; read on a non-ignored accept, rewritten as the item leaves
  always_ff @(posedge clk_i) begin
    if (leave) begin
      line_mem[s1_col_q] <= {rd_q[PIX_W-1:0], s1_pix_q};
    end
    if (load) begin
      rd_q <= bypass ? {rd_q[PIX_W-1:0], s1_pix_q} : line_mem[col_q];
    end
  end

  assign push_valid_o        = s1_valid_q;
  assign push_entry_o.above2 = rd_q[2*PIX_W-1:PIX_W];
  assign push_entry_o.above1 = rd_q[PIX_W-1:0];
  assign push_entry_o.cur    = s1_pix_q;
  assign push_entry_o.ctrl   = s1_ctrl_q;

endmodule

FILE: design/bbe_queue.sv
// Short FIFO between the front end and the blur back end.
// Depends on bbe_pkg.
module bbe_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  bbe_pkg::bbe_entry_t push_entry_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output bbe_pkg::bbe_entry_t pop_entry_o
);
  import bbe_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  bbe_entry_t     entry_q [Q_DEPTH];
  logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;
  logic           push, pop;

  assign push_ready_o = count_q != CW'(Q_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_entry_o = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + CW'(1);
      end else if (pop && !push) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

FILE: design/bbe_back.sv
// Back end: 3x3 window, masked channel sums and rounded divide by reciprocal.
// Depends on bbe_pkg.
module bbe_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                pop_valid_i,
  output logic                pop_ready_o,
  input  bbe_pkg::bbe_entry_t entry_i,
  output logic                m_valid_o,
  input  logic                m_ready_i,
  output bbe_pkg::rgb_t       m_data_o,
  output logic                m_last_o
);
  import bbe_pkg::*;

  localparam int P_W = X_W + REC_W;

  rgb_t             win_q    [3][2];
  rgb_t             win_cell [3][3];
  rgb_t             mval     [3][3];
  logic [SUM_W-1:0] rsum     [NCH][3];
  logic [SUM_W-1:0] sum      [NCH];
  logic [1:0]       rcnt, ccnt;
  logic [CNT_W-1:0] n;
  logic             en, pop;

  logic             b1_valid_q, b1_last_q;
  logic [X_W-1:0]   x_q [NCH];
  logic [REC_W-1:0] m_q;
  logic [P_W-1:0]   prod [NCH];
  logic             out_valid_q, out_last_q;
  rgb_t             out_q;

  assign en  = !out_valid_q || m_ready_i;
  assign pop = pop_valid_i && en;
  assign pop_ready_o = en;

  // post-shift window: two stored columns plus the incoming one
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_cell[r][0] = win_q[r][0];
      win_cell[r][1] = win_q[r][1];
    end
    win_cell[0][2] = entry_i.above2;
    win_cell[1][2] = entry_i.above1;
    win_cell[2][2] = entry_i.cur;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        mval[r][c] = (entry_i.ctrl.row_mask[r] && entry_i.ctrl.col_mask[c]) ?
                     win_cell[r][c] : '0;
      end
    end
    for (int ch = 0; ch < NCH; ch++) begin
      for (int r = 0; r < 3; r++) begin
        rsum[ch][r] = SUM_W'(mval[r][0][ch]) + SUM_W'(mval[r][1][ch]) +
                      SUM_W'(mval[r][2][ch]);
      end
      sum[ch] = rsum[ch][0] + rsum[ch][1] + rsum[ch][2];
    end
  end

  assign rcnt = 2'($countones(entry_i.ctrl.row_mask));
  assign ccnt = 2'($countones(entry_i.ctrl.col_mask));
  assign n    = CNT_W'(rcnt) * CNT_W'(ccnt);

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      prod[ch] = P_W'(x_q[ch]) * P_W'(m_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      b1_valid_q  <= pop && entry_i.ctrl.emit;
      out_valid_q <= b1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_cell[r][2];
      end
    end
    if (en) begin
      for (int ch = 0; ch < NCH; ch++) begin
        x_q[ch] <= {sum[ch], 1'b0} + X_W'(n);
        out_q[ch] <= prod[ch][REC_SHIFT+CH_W-1:REC_SHIFT];
      end
      m_q        <= recip(n);
      b1_last_q  <= entry_i.ctrl.last;
      out_last_q <= b1_last_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;
  assign m_last_o  = out_last_q;

endmodule

FILE: design/box_blur_3x3_edge_aware.sv
// Edge-aware 3x3 box blur on a raster RGB stream: one beat per clock sustained unless stalled.
// Latency: a pixel's output is due W+1 beats after it in the stream; once its last neighbor
// is in, it passes the line-store read, queue, sum stage and divide/output stage registers.
// Throughput: one beat per clock unless stalled; up to one line-store read and one write each clock.
// Reset (async, active low) clears position counters and pipeline valids and loads
// 640x480; the line store and window are not cleared (edge masks hide stale data).
module box_blur_3x3_edge_aware #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // input pixel beats
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  input  logic                           s_axis_tuser,  // command: 0 pixel, 1 flush step
  // output pixel beats
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [23:0]                    m_axis_tdata,  // red[7:0], green[15:8], blue[23:16]
  output logic                           m_axis_tlast,  // frame_end
  // config writes: index 0 frame_width, 1 frame_height
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bbe_pkg::CFG_W-1:0]      cfg_data_i
);
  import bbe_pkg::*;

  rgb_t       in_pix, out_pix;
  logic       push_valid, push_ready, pop_valid, pop_ready;
  bbe_entry_t push_entry, pop_entry;

  // internal channel order is red high
  assign in_pix = {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
  assign m_axis_tdata = {out_pix[0], out_pix[1], out_pix[2]};

  // config writes never stall
  assign cfg_ready_o = 1'b1;

  // front: tracks frame position, drops early flushes, reads/updates line store
  bbe_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .cmd_i        (s_axis_tuser),
    .pix_i        (in_pix),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_entry_o (push_entry),
    .push_ready_i (push_ready)
  );

  // decouples front and back stalls
  bbe_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_entry_o  (pop_entry)
  );

  // back: window shift, masked sums, divide by 2n with round half up
  bbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .entry_i     (pop_entry),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (out_pix),
    .m_last_o    (m_axis_tlast)
  );

endmodule

FILE: verif/tb.sv
// Self-checking testbench for box_blur_3x3_edge_aware: streams RGB frames in, compares every
// blurred output beat against an in-bench prediction of the edge-aware 3x3 mean.
// Depends on design/bbe_pkg.sv and design/box_blur_3x3_edge_aware.sv.
`timescale 1ns / 1ps

module tb;
  import bbe_pkg::*;

  localparam int MAX_W      = 1024;
  localparam int MAX_H      = 1024;
  localparam int SETTLE_CYC = 8;
  localparam int RAND_ITEMS = 120;

  // one blurred pixel as it leaves the block
  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            frame_end;
  } blur_px_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [23:0]       s_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic              s_axis_tuser;   // command: pixel or flush step
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [23:0]       m_axis_tdata;   // red[7:0], green[15:8], blue[23:16]
  logic              m_axis_tlast;   // frame_end
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]  cfg_data_i;

  // per-side idle control: when set, that side never inserts gaps
  bit src_calm;
  bit snk_calm;
  int err_cnt;

  // ---------------------------------------------------------------------------
  // Predictor state: raw size registers, two line buffers, 3x3 window, position
  // ---------------------------------------------------------------------------
  logic [CFG_W-1:0] cfg_w_q;
  logic [CFG_W-1:0] cfg_h_q;
  rgb_t             line_mem [2*MAX_W];  // [0..MAX_W-1] previous row, upper half row before
  rgb_t             win [3][3];          // [row][col], row 0 = top, col 2 = newest
  int               col_pos;
  int               row_pos;
  int               done_cnt;            // outputs already given in this frame
  blur_px_t         blurred_q [$];       // predicted beats not yet seen on the output

  box_blur_3x3_edge_aware #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // 0 acts as 1, anything above the maximum saturates
  function automatic int eff_size(input logic [CFG_W-1:0] raw, input int lim);
    if (raw == '0) return 1;
    if (raw > lim) return lim;
    return int'(raw);
  endfunction

  // Mean of the in-frame neighbors of frame pixel (r, c), centered on window column wc.
  // Rounding is half up: (2*sum + n) / (2*n).
  function automatic blur_px_t window_mean(input int wc, input int r, input int c);
    int       w, h, n, wcol;
    int       sum [3];
    blur_px_t res;
    w   = eff_size(cfg_w_q, MAX_W);
    h   = eff_size(cfg_h_q, MAX_H);
    n   = 0;
    sum = '{0, 0, 0};
    for (int dr = -1; dr <= 1; dr++) begin
      for (int dc = -1; dc <= 1; dc++) begin
        wcol = wc + dc;
        if (r + dr < 0 || r + dr >= h || c + dc < 0 || c + dc >= w) continue;
        if (wcol < 0 || wcol > 2) continue;
        for (int k = 0; k < NCH; k++) sum[k] += int'(win[dr+1][wcol][k]);
        n++;
      end
    end
    if (n == 0) n = 1;
    res.red       = CH_W'((2 * sum[2] + n) / (2 * n));
    res.green     = CH_W'((2 * sum[1] + n) / (2 * n));
    res.blue      = CH_W'((2 * sum[0] + n) / (2 * n));
    res.frame_end = 1'b0;
    return res;
  endfunction

  function automatic void frame_restart();
    col_pos  = 0;
    row_pos  = 0;
    done_cnt = 0;
  endfunction

  function automatic void model_reset();
    cfg_w_q = CFG_W'(WIDTH_RESET);
    cfg_h_q = CFG_W'(HEIGHT_RESET);
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (win[i, j]) win[i][j] = '0;
    frame_restart();
  endfunction

  // any register write starts a fresh frame; a partial frame is dropped
  function automatic void cfg_update(input logic [CFG_IDX_W-1:0] idx,
                                     input logic [CFG_W-1:0] val);
    if (idx == REG_WIDTH) cfg_w_q = val;
    else cfg_h_q = val;
    frame_restart();
  endfunction

  // Advance the blur state by one accepted input beat, queue the output it causes.
  task automatic blur_step(input logic cmd, input rgb_t px);
    int       w, h, col, row;
    bit       drain, got;
    rgb_t     cur, up2, up1;
    blur_px_t res;
    w     = eff_size(cfg_w_q, MAX_W);
    h     = eff_size(cfg_h_q, MAX_H);
    row   = row_pos;
    col   = col_pos;
    drain = (row >= h);
    got   = 1'b0;
    // flush before the frame is complete does nothing
    if (!drain && cmd == CMD_FLUSH) return;
    // once the frame is complete every beat is a flush step, data ignored
    cur = drain ? '0 : px;
    if (col >= w) col = 0;

    // row start: last pixel of row-2 is due, taken from the unshifted window
    if (col == 0 && row >= 2 && row - 2 < h) begin
      res = window_mean(2, row - 2, w - 1);
      got = 1'b1;
    end

    up2 = line_mem[MAX_W + col];
    up1 = line_mem[col];
    line_mem[MAX_W + col] = up1;
    line_mem[col]         = cur;
    for (int k = 0; k < 3; k++) begin
      win[k][0] = win[k][1];
      win[k][1] = win[k][2];
    end
    win[0][2] = up2;
    win[1][2] = up1;
    win[2][2] = cur;

    if (col >= 1 && row >= 1 && row - 1 < h) begin
      res = window_mean(1, row - 1, col - 1);
      got = 1'b1;
    end

    col++;
    if (col >= w) begin
      col = 0;
      row++;
    end
    col_pos = col;
    row_pos = row;

    if (got) begin
      res.frame_end = (done_cnt + 1 >= w * h);
      blurred_q.push_back(res);
      done_cnt++;
      if (res.frame_end) frame_restart();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus primitives
  // ---------------------------------------------------------------------------

  function automatic rgb_t rand_px();
    return {CH_W'($urandom), CH_W'($urandom), CH_W'($urandom)};
  endfunction

  // One input beat. Valid stays high across back-to-back beats (gap 0), so it is
  // never lowered and raised in the same step.
  task automatic send_beat(input logic cmd, input rgb_t px);
    int gap;
    gap = src_calm ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {px[0], px[1], px[2]};  // blue, green, red from the top down
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    blur_step(cmd, px);
  endtask

  // Stop the input stream, let every predicted beat come out, then let the pipe settle.
  task automatic wait_all_out();
    s_axis_tvalid <= 1'b0;
    while (blurred_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    wait_all_out();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    cfg_valid_i <= 1'b0;
    cfg_update(idx, val);
  endtask

  task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // npix pixels (with the odd stray flush mixed in, which must be ignored), then
  // ndrain drain steps, each a flush or a pixel with junk data.
  task automatic run_frame(input int npix, input int ndrain, input bit patterned);
    rgb_t px;
    for (int i = 0; i < npix; i++) begin
      if ($urandom_range(0, 11) == 0) send_beat(CMD_FLUSH, rand_px());
      if (patterned)
        // red toggles full scale, green hits .5 rounding cases, blue ramps down
        px = {(i[0] ? 8'hFF : 8'h00), ((i % 3 == 0) ? 8'd1 : 8'd0), CH_W'(255 - 17 * i)};
      else
        px = rand_px();
      send_beat(CMD_PIXEL, px);
    end
    for (int i = 0; i < ndrain; i++)
      send_beat($urandom_range(0, 1) ? CMD_FLUSH : CMD_PIXEL, rand_px());
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Tiny frames hitting every divisor: 1 (1x1), 2 (2x1), 2/3 (1x3), 4/6/9 (3x3).
  task automatic test_divisors();
    src_calm = 1'b0;
    snk_calm = 1'b0;
    set_frame(11'd1, 11'd1);
    run_frame(1, 2, 1'b1);
    set_frame(11'd2, 11'd1);
    run_frame(2, 3, 1'b1);
    set_frame(11'd1, 11'd3);
    run_frame(3, 2, 1'b1);
    set_frame(11'd3, 11'd3);
    run_frame(9, 4, 1'b1);
  endtask

  // A register write in the middle of a frame drops it; the next frame starts clean.
  task automatic test_frame_abort();
    set_frame(11'd5, 11'd4);
    run_frame(8, 0, 1'b0);
    write_reg(REG_HEIGHT, 11'd4);
    run_frame(20, 6, 1'b0);
  endtask

  // Out-of-range register values: 2047 saturates to the max, 0 acts as 1.
  // The wide frame fills the whole line-store depth and drains in part; the tall
  // frame is cut short. Both are dropped by the next register write.
  task automatic test_reg_limits();
    src_calm = 1'b1;
    set_frame(11'h7FF, 11'd0);  // 1024 x 1
    run_frame(MAX_W, 16, 1'b0);
    src_calm = 1'b0;
    set_frame(11'd0, 11'h7FF);  // 1 x 1024
    run_frame(24, 0, 1'b0);
    set_frame(11'd8, 11'd8);
  endtask

  // Random frames, mostly small and well formed, some cut short by a register write,
  // some sent back to back with no reconfiguration.
  task automatic test_random_frames();
    int               sent, w, h, k, npix, ndrain;
    logic [CFG_W-1:0] raw_w, raw_h;
    sent = 0;
    while (sent < RAND_ITEMS) begin
      src_calm = ($urandom_range(0, 3) == 0);
      snk_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       raw_w = '0;
          1:       raw_w = CFG_W'($urandom_range(17, 48));
          default: raw_w = CFG_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 9))
          0:       raw_h = '0;
          1:       raw_h = CFG_W'($urandom_range(9, 12));
          default: raw_h = CFG_W'($urandom_range(1, 8));
        endcase
        set_frame(raw_w, raw_h);
      end
      w = eff_size(cfg_w_q, MAX_W);
      h = eff_size(cfg_h_q, MAX_H);
      if ($urandom_range(0, 7) == 0) begin
        // broken frame: stop anywhere in pixels or drain, then drop it
        k      = $urandom_range(0, w * h + w);
        npix   = (k < w * h) ? k : w * h;
        ndrain = k - npix;
        run_frame(npix, ndrain, 1'b0);
        write_reg(REG_HEIGHT, cfg_h_q);
        sent += k;
      end else begin
        run_frame(w * h, w + 1, 1'b0);
        sent += w * h + w + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall before each beat, checked against the oldest prediction
  // ---------------------------------------------------------------------------
  initial begin : sink
    int stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = snk_calm ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1));
    end
  end

  always @(posedge clk_i) begin : check_out
    blur_px_t seen, want;
    if (rst_ni === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      seen = {m_axis_tdata[7:0], m_axis_tdata[15:8], m_axis_tdata[23:16], m_axis_tlast};
      if (blurred_q.size() == 0) begin
        if (err_cnt < 10)
          $display("%0t: output beat with nothing pending: r=%0d g=%0d b=%0d last=%b",
                   $time, seen.red, seen.green, seen.blue, seen.frame_end);
        err_cnt++;
      end else begin
        want = blurred_q.pop_front();
        if (seen !== want) begin
          if (err_cnt < 10)
            $display("%0t: mismatch exp r=%0d g=%0d b=%0d last=%b got r=%0d g=%0d b=%0d last=%b",
                     $time, want.red, want.green, want.blue, want.frame_end,
                     seen.red, seen.green, seen.blue, seen.frame_end);
          err_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    err_cnt       = 0;
    src_calm      = 1'b0;
    snk_calm      = 1'b0;
    model_reset();
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= CMD_PIXEL;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= REG_WIDTH;
    cfg_data_i    <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_divisors();
    test_frame_abort();
    test_reg_limits();
    test_random_frames();

    wait_all_out();
    if (err_cnt == 0 && blurred_q.size() == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #4ms;
    $display("tb failed");
    $finish;
  end

endmodule

FILE: files.f
design/bbe_pkg.sv
design/bbe_front.sv
design/bbe_queue.sv
design/bbe_back.sv
design/box_blur_3x3_edge_aware.sv
verif/tb.sv
